@@ src/tree_plru_fully_assoc_cache_unit_macros.svh @@
// Assertion helpers shared by the cache unit RTL.
// Each check is sampled on the rising clock and is off while reset is held.
`ifndef TREE_PLRU_FULLY_ASSOC_CACHE_UNIT_MACROS_SVH
`define TREE_PLRU_FULLY_ASSOC_CACHE_UNIT_MACROS_SVH

// Same-cycle implication.
`define TPLRU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tplru: same-cycle check failed");

// Next-cycle implication.
`define TPLRU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tplru: next-cycle check failed");

`endif

@@ src/tplru_pkg.sv @@
package tplru_pkg;

    localparam int WAYS_DEF        = 512;
    localparam int OFFSET_BITS_DEF = 5;
    localparam int ADDR_W          = 32;
    localparam int WAY_FIELD_W     = 9;
    localparam int COUNT_W         = 32;

    // Per-cycle command to a single-port-write, single-port-read memory
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_cmd_t;

endpackage

@@ src/tplru_front.sv @@
module tplru_front #(
    parameter int OFFSET_BITS = tplru_pkg::OFFSET_BITS_DEF,
    localparam int TAG_W = tplru_pkg::ADDR_W - OFFSET_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tplru_pkg::ADDR_W-1:0] address,
    output logic                        tag_valid,
    output logic [TAG_W-1:0]            tag,
    input  logic                        tag_pop
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [TAG_W-1:0] q_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_stall  = (count_reg == CNT_W'(DEPTH));
    assign tag_valid = (count_reg != '0);
    assign tag       = q_reg[rd_ptr_reg];

    assign push = in_valid && !in_stall;
    assign pop  = tag_pop && tag_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // strip the line offset on the way in
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= address[tplru_pkg::ADDR_W-1:OFFSET_BITS];
        end
    end

endmodule

@@ src/tplru_tags.sv @@
module tplru_tags #(
    parameter int WAYS        = tplru_pkg::WAYS_DEF,
    parameter int OFFSET_BITS = tplru_pkg::OFFSET_BITS_DEF,
    localparam int TAG_W = tplru_pkg::ADDR_W - OFFSET_BITS,
    localparam int WAY_W = $clog2(WAYS)
) (
    input  logic                clk,
    input  tplru_pkg::mem_cmd_t cmd,
    input  logic [WAY_W-1:0]    wr_addr,
    input  logic                wr_valid,
    input  logic [TAG_W-1:0]    wr_tag,
    input  logic [WAY_W-1:0]    rd_addr,
    input  logic [TAG_W-1:0]    key,
    output logic                match
);

    // entry = {valid, tag}
    logic [TAG_W:0] mem [WAYS];
    logic [TAG_W:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= {wr_valid, wr_tag};
        end
        if (cmd.rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign match = rd_reg[TAG_W] && (rd_reg[TAG_W-1:0] == key);

endmodule

@@ src/tplru_tree.sv @@
module tplru_tree #(
    parameter int WAYS = tplru_pkg::WAYS_DEF,
    localparam int WAY_W   = $clog2(WAYS),
    localparam int NODES   = WAYS - 1,
    localparam int NODE_AW = (NODES > 1) ? $clog2(NODES) : 1
) (
    input  logic                clk,
    input  tplru_pkg::mem_cmd_t cmd,
    input  logic [WAY_W-1:0]    wr_node,
    input  logic                wr_bit,
    input  logic [WAY_W-1:0]    rd_node,
    output logic                rd_bit
);

    logic             mem [NODES];
    logic             rd_reg;
    logic             rd_in_reg;
    logic             wr_in;
    logic             rd_in;

    // nodes past the last one exist only for non-power-of-two sizes; they read as zero
    assign wr_in = (wr_node < WAY_W'(NODES));
    assign rd_in = (rd_node < WAY_W'(NODES));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_in)
        begin
            mem[wr_node[NODE_AW-1:0]] <= wr_bit;
        end
        if (cmd.rd_en)
        begin
            rd_reg    <= mem[rd_node[NODE_AW-1:0]];
            rd_in_reg <= rd_in;
        end
    end

    assign rd_bit = rd_in_reg && rd_reg;

endmodule

@@ src/tree_plru_fully_assoc_cache_unit.sv @@
// Fully associative tag lookup with tree pseudo-LRU replacement.
// Reset: async, active low; then a clearing pass over both memories before the first item.
// Hit in way k: the scan stops at way k, then the hit path is refreshed.
// Miss: the tag memory scan reads every way, one entry a cycle, then the victim walk runs.
// One item is handled at a time; a two-entry queue takes input meanwhile.
`include "tree_plru_fully_assoc_cache_unit_macros.svh"

module tree_plru_fully_assoc_cache_unit #(
    parameter int WAYS        = tplru_pkg::WAYS_DEF,
    parameter int OFFSET_BITS = tplru_pkg::OFFSET_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tplru_pkg::ADDR_W-1:0]      address,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic [tplru_pkg::WAY_FIELD_W-1:0] way,
    output logic [tplru_pkg::COUNT_W-1:0]     hit_count
);

    localparam int TAG_W   = tplru_pkg::ADDR_W - OFFSET_BITS;
    localparam int WAY_W   = $clog2(WAYS);
    // tree depth rounds up, so the level count equals the way index width
    localparam int LEVELS  = WAY_W;
    localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int FIELD_W = tplru_pkg::WAY_FIELD_W;
    localparam int COUNT_W = tplru_pkg::COUNT_W;

    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);
    localparam logic [WAY_W:0]   WAYS_X   = (WAY_W + 1)'(WAYS);
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);

    // Back-end sequencer
    //   S_CLEAR : sweep both memories after reset
    //   S_IDLE  : dequeue a tag, start the scan at way 0
    //   S_SCAN  : compare one stored way per cycle, lowest way first
    //   S_HUPD  : point each node on the hit path away from the hit way
    //   S_WREAD : fetch the root node for the victim walk
    //   S_WFLIP : follow and flip one node per cycle, fill the victim at the leaf
    //   S_RES   : hand the result to the output register
    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_HUPD  = 7'b0001000,
        S_WREAD = 7'b0010000,
        S_WFLIP = 7'b0100000,
        S_RES   = 7'b1000000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [WAY_W-1:0]   clr_reg;
    logic [WAY_W-1:0]   clr_next;
    logic [TAG_W-1:0]   tag_reg;
    logic [TAG_W-1:0]   tag_next;
    logic [WAY_W-1:0]   chk_reg;
    logic [WAY_W-1:0]   chk_next;
    logic [LVL_W-1:0]   lvl_reg;
    logic [LVL_W-1:0]   lvl_next;
    logic [WAY_W-1:0]   node_reg;
    logic [WAY_W-1:0]   node_next;
    logic [WAY_W-1:0]   pos_reg;
    logic [WAY_W-1:0]   pos_next;
    logic [WAY_W-1:0]   path_reg;
    logic [WAY_W-1:0]   path_next;
    logic               res_hit_reg;
    logic               res_hit_next;
    logic [WAY_W-1:0]   res_way_reg;
    logic [WAY_W-1:0]   res_way_next;
    logic [COUNT_W-1:0] hits_reg;
    logic [COUNT_W-1:0] hits_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_hit_reg;
    logic [FIELD_W-1:0] out_way_reg;
    logic [COUNT_W-1:0] out_count_reg;

    // front-end queue interface
    logic               q_valid;
    logic [TAG_W-1:0]   q_tag;
    logic               q_pop;

    // memory side
    tplru_pkg::mem_cmd_t tag_cmd;
    logic [WAY_W-1:0]    tag_wr_addr;
    logic                tag_wr_valid;
    logic [WAY_W-1:0]    tag_rd_addr;
    logic                tag_match;
    tplru_pkg::mem_cmd_t tree_cmd;
    logic [WAY_W-1:0]    tree_wr_node;
    logic                tree_wr_bit;
    logic [WAY_W-1:0]    tree_rd_node;
    logic                tree_rd_bit;

    // walk datapath
    logic                     lvl_last;
    logic                     step_bit;
    logic [WAY_W-1:0]         walk_node;
    logic [WAY_W-1:0]         walk_pos;
    logic [WAY_W:0]           pos_ext;
    logic [WAY_W-1:0]         fill_way;
    logic                     fill_en;
    logic                     res_load;
    logic                     out_fire;
    logic [WAY_W+FIELD_W-1:0] way_wide;

    tplru_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .address   (address),
        .tag_valid (q_valid),
        .tag       (q_tag),
        .tag_pop   (q_pop)
    );

    tplru_tags #(
        .WAYS        (WAYS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_tags (
        .clk      (clk),
        .cmd      (tag_cmd),
        .wr_addr  (tag_wr_addr),
        .wr_valid (tag_wr_valid),
        .wr_tag   (tag_reg),
        .rd_addr  (tag_rd_addr),
        .key      (tag_reg),
        .match    (tag_match)
    );

    tplru_tree #(
        .WAYS (WAYS)
    ) u_tree (
        .clk     (clk),
        .cmd     (tree_cmd),
        .wr_node (tree_wr_node),
        .wr_bit  (tree_wr_bit),
        .rd_node (tree_rd_node),
        .rd_bit  (tree_rd_bit)
    );

    // Tree step: on a hit the direction comes from the hit way's bits (MSB first),
    // on a miss from the node just read. Heap order: children of n are 2n+1, 2n+2.
    assign lvl_last  = (lvl_reg == LVL_LAST);
    assign step_bit  = (state_reg == S_HUPD) ? path_reg[WAY_W-1] : tree_rd_bit;
    assign walk_node = (node_reg << 1) + WAY_W'(1) + WAY_W'(step_bit);
    assign walk_pos  = (pos_reg << 1) | WAY_W'(step_bit);

    // victim past the last way wraps; it is always below twice WAYS
    assign pos_ext  = {1'b0, walk_pos};
    assign fill_way = (pos_ext >= WAYS_X) ? WAY_W'(pos_ext - WAYS_X) : walk_pos;
    assign fill_en  = (state_reg == S_WFLIP) && lvl_last;

    // tag memory: clear sweep or victim fill on the write side, scan on the read side
    always_comb
    begin
        tag_cmd.wr_en = (state_reg == S_CLEAR) || fill_en;
        tag_cmd.rd_en = ((state_reg == S_IDLE) && q_valid)
                     || ((state_reg == S_SCAN) && !tag_match && (chk_reg != LAST_WAY));
        tag_wr_addr   = (state_reg == S_CLEAR) ? clr_reg : fill_way;
        tag_wr_valid  = (state_reg != S_CLEAR);
        tag_rd_addr   = (state_reg == S_IDLE) ? '0 : chk_reg + WAY_W'(1);
    end

    // tree memory: write the current node, read ahead to its child during the walk
    always_comb
    begin
        tree_cmd.wr_en = (state_reg == S_CLEAR) || (state_reg == S_HUPD)
                      || (state_reg == S_WFLIP);
        tree_cmd.rd_en = (state_reg == S_WREAD) || ((state_reg == S_WFLIP) && !lvl_last);
        tree_wr_node   = (state_reg == S_CLEAR) ? clr_reg : node_reg;
        tree_wr_bit    = (state_reg == S_CLEAR) ? 1'b0 : !step_bit;
        tree_rd_node   = (state_reg == S_WREAD) ? node_reg : walk_node;
    end

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_fire = out_valid_reg && !out_stall;
    assign res_load = (state_reg == S_RES) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        tag_next     = tag_reg;
        chk_next     = chk_reg;
        lvl_next     = lvl_reg;
        node_next    = node_reg;
        pos_next     = pos_reg;
        path_next    = path_reg;
        res_hit_next = res_hit_reg;
        res_way_next = res_way_reg;
        hits_next    = hits_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + WAY_W'(1);
                if (clr_reg == LAST_WAY)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    tag_next   = q_tag;
                    chk_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tag_match)
                begin
                    // hit: count it (saturate) and refresh the path
                    if (hits_reg != '1)
                    begin
                        hits_next = hits_reg + COUNT_W'(1);
                    end
                    res_hit_next = 1'b1;
                    res_way_next = chk_reg;
                    path_next    = chk_reg;
                    node_next    = '0;
                    lvl_next     = '0;
                    state_next   = S_HUPD;
                end
                else if (chk_reg == LAST_WAY)
                begin
                    // miss: go find a victim
                    res_hit_next = 1'b0;
                    node_next    = '0;
                    pos_next     = '0;
                    lvl_next     = '0;
                    state_next   = S_WREAD;
                end
                else
                begin
                    chk_next = chk_reg + WAY_W'(1);
                end
            end
            S_HUPD:
            begin
                node_next = walk_node;
                path_next = path_reg << 1;
                lvl_next  = lvl_reg + LVL_W'(1);
                if (lvl_last)
                begin
                    state_next = S_RES;
                end
            end
            S_WREAD:
            begin
                state_next = S_WFLIP;
            end
            S_WFLIP:
            begin
                node_next = walk_node;
                pos_next  = walk_pos;
                lvl_next  = lvl_reg + LVL_W'(1);
                if (lvl_last)
                begin
                    res_way_next = fill_way;
                    state_next   = S_RES;
                end
            end
            S_RES:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            lvl_reg   <= '0;
            hits_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            lvl_reg   <= lvl_next;
            hits_reg  <= hits_next;
        end
    end

    // per-item working registers: no reset needed
    always_ff @(posedge clk)
    begin
        tag_reg     <= tag_next;
        chk_reg     <= chk_next;
        node_reg    <= node_next;
        pos_reg     <= pos_next;
        path_reg    <= path_next;
        res_hit_reg <= res_hit_next;
        res_way_reg <= res_way_next;
    end

    // Output register: load a finished result when the slot is empty or draining,
    // drop the valid once the consumer takes the item.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // way field keeps only its low bits when the way index is wider
    assign way_wide = {{FIELD_W{1'b0}}, res_way_reg};

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_hit_reg   <= res_hit_reg;
            out_way_reg   <= way_wide[FIELD_W-1:0];
            out_count_reg <= hits_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign way       = out_way_reg;
    assign hit_count = out_count_reg;

    // a filled victim must land on a real way
    `TPLRU_ASSERT_IMP(a_fill_in_range, fill_en, fill_way < WAYS)
    // the tree walk never runs past its last level
    `TPLRU_ASSERT_IMP(a_hupd_depth, state_reg == S_HUPD, lvl_reg <= LVL_LAST)
    `TPLRU_ASSERT_IMP(a_wflip_depth, state_reg == S_WFLIP, lvl_reg <= LVL_LAST)
    // the hit counter moves by at most one per cycle
    `TPLRU_ASSERT_NXT(a_hits_step, 1'b1, (hits_reg - $past(hits_reg)) <= COUNT_W'(1))

endmodule
